// ----- rtl/core/deq_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
// No dependencies; every other file in rtl/core imports this package.
package deq_pkg;

   localparam int DefaultDepth  = 16;
   localparam int DataWidth     = 32;
   localparam int OpWidth       = 3;
   localparam int CountWidth    = 5;
   localparam int StatusWidth   = 2;
   localparam int CmdQueueDepth = 2;

   localparam logic [CountWidth-1:0] CapacityResetValue = 5'd16;

   typedef enum logic [OpWidth-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_NOP  = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_POP  = 2'd2,
      CMD_PEEK = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic                 at_front;
      logic [DataWidth-1:0] value;
   } cmd_type;

endpackage

// ----- rtl/core/deq_front.sv -----
// Front end: accepts requests and decodes the op code into a command.
// Depends on deq_pkg.
module deq_front
   import deq_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OpWidth-1:0]   req_op,
   input  logic [DataWidth-1:0] req_push_value,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output cmd_type              cmd
);

   always_comb begin
      cmd.value    = req_push_value;
      cmd.kind     = CMD_NOP;
      cmd.at_front = 1'b0;
      unique case (op_type'(req_op))
         OP_PUSH_FRONT: begin
            cmd.kind     = CMD_PUSH;
            cmd.at_front = 1'b1;
         end
         OP_PUSH_BACK: begin
            cmd.kind = CMD_PUSH;
         end
         OP_POP_FRONT: begin
            cmd.kind     = CMD_POP;
            cmd.at_front = 1'b1;
         end
         OP_POP_BACK: begin
            cmd.kind = CMD_POP;
         end
         OP_PEEK_FRONT: begin
            cmd.kind     = CMD_PEEK;
            cmd.at_front = 1'b1;
         end
         OP_PEEK_BACK: begin
            cmd.kind = CMD_PEEK;
         end
         default: begin
            // unused codes: report fill only
            cmd.kind = CMD_NOP;
         end
      endcase
   end

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

endmodule

// ----- rtl/core/deq_cmd_fifo.sv -----
// Short command queue between the front end and the execution back end.
// Depends on deq_pkg.
module deq_cmd_fifo
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   localparam int QPW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
   localparam int QCW = $clog2(CmdQueueDepth + 1);

   cmd_type          slot_ff [CmdQueueDepth];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != QCW'(CmdQueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(CmdQueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(CmdQueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ----- rtl/core/deq_back.sv -----
// Back end: ring store, head pointer and fill count; executes one command
// per cycle into a response register, unless stalled by rsp_ready. Depends on deq_pkg.
module deq_back
   import deq_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CountWidth-1:0]  capacity_limit,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  cmd_type                cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DataWidth-1:0]   rsp_read_value,
   output logic [CountWidth-1:0]  rsp_fill_count,
   output logic [StatusWidth-1:0] rsp_status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = CountWidth;
   localparam int SW = ((PW > CW) ? PW : CW) + 1;

   logic [DataWidth-1:0]   store_mem [DEPTH];
   logic [PW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]   read_value_ff;
   logic [CW-1:0]          fill_ff;
   status_type             status_ff, status_in;

   logic                   exec, empty, full, do_write, do_read;
   logic [SW-1:0]          head_ext, count_ext;
   logic [PW-1:0]          head_dec, head_inc, tail_pos, last_pos;
   logic [PW-1:0]          wr_addr, rd_addr;

   function automatic logic [PW-1:0] wrap_pos(input logic [SW-1:0] sum);
      logic [SW-1:0] d;
      d = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
      return d[PW-1:0];
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign exec      = cmd_valid && cmd_ready;

   assign head_ext  = {{(SW-PW){1'b0}}, head_ff};
   assign count_ext = {{(SW-CW){1'b0}}, count_ff};
   assign head_dec  = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc  = wrap_pos(head_ext + SW'(1));
   assign tail_pos  = wrap_pos(head_ext + count_ext);
   assign last_pos  = wrap_pos(head_ext + count_ext - SW'(1));

   assign empty    = (count_ff == '0);
   assign full     = (count_ff >= capacity_limit) || (int'(count_ff) >= DEPTH);
   assign do_write = exec && (cmd.kind == CMD_PUSH) && !full;
   assign do_read  = exec && ((cmd.kind == CMD_POP) || (cmd.kind == CMD_PEEK)) && !empty;
   assign wr_addr  = cmd.at_front ? head_dec : tail_pos;
   assign rd_addr  = cmd.at_front ? head_ff : last_pos;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      if (do_write) begin
         count_in = count_ff + 1'b1;
         if (cmd.at_front) begin
            head_in = head_dec;
         end
      end
      if (do_read && (cmd.kind == CMD_POP)) begin
         count_in = count_ff - 1'b1;
         if (cmd.at_front) begin
            head_in = head_inc;
         end
      end
      case (cmd.kind) inside
         CMD_PUSH: status_in = full ? ST_FULL : ST_OK;
         CMD_POP, CMD_PEEK: status_in = empty ? ST_EMPTY : ST_OK;
         default: status_in = ST_OK;
      endcase
      rsp_valid_in = exec || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // store write, registered read, response payload
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[wr_addr] <= cmd.value;
      end
      if (exec) begin
         read_value_ff <= do_read ? store_mem[rd_addr] : '0;
         fill_ff       <= count_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_fill_count = fill_ff;
   assign rsp_status     = status_ff;

endmodule

// ----- rtl/core/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: capacity register and the
// front end, command queue and back end. Depends on deq_pkg and the deq_* modules.
//
// Usage:
//   req_*  : request channel. req_op selects push front/back, pop front/back,
//            peek front/back; req_push_value is stored by pushes.
//   rsp_*  : one response per request, in order: rsp_read_value (popped or
//            peeked word, zero otherwise), rsp_fill_count (fill after the
//            request) and rsp_status (ok, empty, full).
//   csr_*  : write port for the usable capacity; write it only while idle.
// Path: a request is written into the command queue, then executed by the back end
//   into the response register, which drives rsp_valid.
// Throughput: one request per cycle while responses are taken, set by the back end,
//   which reads or writes the ring store once and updates head and fill together.
// Reset: head and fill clear to zero, capacity returns to 16; the store
//   keeps whatever it held, and only live entries are ever read.
// Stall: while rsp_ready is low the response register holds; the two-entry
//   command queue absorbs requests, then req_ready drops.
module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [OpWidth-1:0]            req_op,
   input  logic signed [DataWidth-1:0]   req_push_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DataWidth-1:0]   rsp_read_value,
   output logic [CountWidth-1:0]         rsp_fill_count,
   output logic [StatusWidth-1:0]        rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CountWidth-1:0]         csr_capacity_limit
);

   logic [CountWidth-1:0] capacity_limit_ff;
   logic                  front_valid, front_ready;
   cmd_type               front_cmd;
   logic                  back_valid, back_ready;
   cmd_type               back_cmd;
   logic [DataWidth-1:0]  read_value;

   // capacity register: always ready; the user is to write it between bursts, the block has no check for this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_limit_ff <= CapacityResetValue;
      end else if (csr_valid) begin
         capacity_limit_ff <= csr_capacity_limit;
      end
   end

   // decode the op code into a command
   deq_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   // decouple decode from execution
   deq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   // execute against the ring store
   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .capacity_limit (capacity_limit_ff),
      .cmd_valid      (back_valid),
      .cmd_ready      (back_ready),
      .cmd            (back_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (read_value),
      .rsp_fill_count (rsp_fill_count),
      .rsp_status     (rsp_status)
   );

   assign rsp_read_value = read_value;

`ifndef NO_ASSERTIONS
   // fill never exceeds the built depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_fill_count) <= DEPTH))
      else $error("fill count above depth");

   // a full report only when the fill has reached the usable capacity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         ((rsp_fill_count >= capacity_limit_ff) || (int'(rsp_fill_count) >= DEPTH)))
      else $error("full reported below capacity");

   // an empty report carries zero fill and zero data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_fill_count == '0 && rsp_read_value == '0))
      else $error("empty report with data or fill");

   // an error never returns data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_value == '0))
      else $error("data returned with error status");
`endif

endmodule

// ----- tb/tb_double_ended_queue_unit.sv -----
// Self-checking testbench for the double-ended queue unit: directed corner cases, then
// random push/pop/peek traffic under several capacity settings, checked against a predictor.
// Depends on deq_pkg and the RTL under rtl/core.
module tb_double_ended_queue_unit
   import deq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth         = DefaultDepth;
   localparam int PtrWidth      = $clog2(Depth);
   localparam int ClockPeriod   = 20;
   localparam int HoldOffCycles = 40;
   localparam int PhaseItems    = 102;
   localparam int TimeoutCycles = 600000;

   // Op codes 6 and 7 have no meaning; the unit must answer them as no-ops.
   localparam logic [OpWidth-1:0] OpSpare6 = 3'd6;
   localparam logic [OpWidth-1:0] OpSpare7 = 3'd7;

   typedef struct {
      logic [OpWidth-1:0]   op;
      logic [DataWidth-1:0] value;
   } deq_request_type;

   typedef struct {
      logic [DataWidth-1:0]  read_value;
      logic [CountWidth-1:0] fill_count;
      status_type            status;
   } deq_response_type;

   logic                        clock;
   logic                        reset              = 1'b1;
   logic                        req_valid          = 1'b0;
   logic                        req_ready;
   logic [OpWidth-1:0]          req_op             = '0;
   logic signed [DataWidth-1:0] req_push_value     = '0;
   logic                        rsp_valid;
   logic                        rsp_ready          = 1'b0;
   logic signed [DataWidth-1:0] rsp_read_value;
   logic [CountWidth-1:0]       rsp_fill_count;
   logic [StatusWidth-1:0]      rsp_status;
   logic                        csr_valid          = 1'b0;
   logic                        csr_ready;
   logic [CountWidth-1:0]       csr_capacity_limit = '0;

   double_ended_queue_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_capacity_limit(csr_capacity_limit)
   );

   always begin
      clock = 1'b0;
      #(ClockPeriod / 2);
      clock = 1'b1;
      #(ClockPeriod / 2);
   end

   // ---------------------------------------------------------------------------------------
   // Predictor state: the ring store, front pointer, fill and the capacity setting, kept in
   // step with every request the unit accepts.
   // ---------------------------------------------------------------------------------------
   logic [DataWidth-1:0]  ring_store [Depth];
   logic [PtrWidth-1:0]   front_ptr   = '0;
   logic [CountWidth-1:0] fill        = '0;
   logic [CountWidth-1:0] cap_setting = CapacityResetValue;

   deq_request_type  queued_requests [$];
   deq_response_type predicted_responses [$];
   deq_request_type  next_req;
   deq_response_type oldest_rsp;

   int reqs_offered     = 0;
   int reqs_taken       = 0;
   int rsps_checked     = 0;
   int mismatches       = 0;
   int full_rejects     = 0;
   int empty_hits       = 0;
   int peak_fill        = 0;
   int settings_applied = 0;

   // Traffic shaping, set by the stimulus process between phases.
   bit sender_eager   = 1'b0;
   bit receiver_eager = 1'b0;
   bit hold_off_req   = 1'b0;

   int unsigned send_gap_left = 0;
   int unsigned recv_gap_left = 0;
   int unsigned hold_off_left = 0;

   logic [CountWidth-1:0] phase_limits [11] = '{5'd31, 5'd16, 5'd16, 5'd1, 5'd0, 5'd7,
                                                5'd16, 5'd3, 5'd2, 5'd12, 5'd16};

   // Advance the predictor by one accepted request and queue the response it must produce.
   task automatic predict_deque_response(input logic [OpWidth-1:0]   op,
                                         input logic [DataWidth-1:0] value);
      deq_response_type      rsp;
      logic [CountWidth-1:0] room;
      logic [PtrWidth-1:0]   slot;
      rsp.read_value = '0;
      rsp.status     = ST_OK;
      // Settings above the built depth clamp to the depth.
      room = (cap_setting < Depth) ? cap_setting : CountWidth'(Depth);
      case (op) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            // Drop the push when full; a lowered limit can leave fill above room.
            if (fill >= room) begin
               rsp.status = ST_FULL;
               full_rejects++;
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  front_ptr = front_ptr - 1'b1;
                  slot      = front_ptr;
               end else begin
                  slot = front_ptr + fill[PtrWidth-1:0];
               end
               ring_store[slot] = value;
               fill++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (fill == 0) begin
               rsp.status = ST_EMPTY;
               empty_hits++;
            end else begin
               if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
                  slot = front_ptr;
               end else begin
                  slot = front_ptr + fill[PtrWidth-1:0] - 1'b1;
               end
               rsp.read_value = ring_store[slot];
               if (op == OP_POP_FRONT) begin
                  front_ptr = front_ptr + 1'b1;
                  fill--;
               end else if (op == OP_POP_BACK) begin
                  fill--;
               end
            end
         end
         default: begin
            // Spare codes leave the state alone.
         end
      endcase
      rsp.fill_count = fill;
      if (fill > peak_fill) peak_fill = fill;
      predicted_responses.insert(predicted_responses.size(), rsp);
   endtask

   function automatic void check_field(input string                field,
                                       input logic [DataWidth-1:0] expected_v,
                                       input logic [DataWidth-1:0] actual_v);
      if (actual_v !== expected_v) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                  $time, field, expected_v, actual_v);
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. Check the response first, since a
   // request accepted at this same edge cannot have produced it yet.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsps_checked++;
            if (predicted_responses.size() == 0) begin
               mismatches++;
               $display("%0t ns: response with nothing expected, expected none, %s 'h%0h/%0d/%0d",
                        $time, "actual", rsp_read_value, rsp_fill_count, rsp_status);
            end else begin
               oldest_rsp = predicted_responses[0];
               predicted_responses.delete(0);
               check_field("read_value", oldest_rsp.read_value, rsp_read_value);
               check_field("fill_count", DataWidth'(oldest_rsp.fill_count),
                           DataWidth'(rsp_fill_count));
               check_field("status", DataWidth'(oldest_rsp.status), DataWidth'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            reqs_taken++;
            predict_deque_response(req_op, req_push_value);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Driver: present requests at the falling edge. Hold valid and payload while a request is
   // waiting; once it is taken, either idle for the drawn gap or present the next request.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || (req_valid && reqs_offered != reqs_taken)) begin
         // hold the current request until accepted
      end else if (send_gap_left != 0) begin
         send_gap_left--;
         req_valid <= 1'b0;
      end else if (queued_requests.size() != 0) begin
         next_req = queued_requests[0];
         queued_requests.delete(0);
         req_valid      <= 1'b1;
         req_op         <= next_req.op;
         req_push_value <= next_req.value;
         reqs_offered++;
         send_gap_left = sender_eager ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: stall rsp_ready at random. On request, hold off for a long stretch so the
   // command queue fills and the unit drops req_ready.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else if (hold_off_req) begin
         hold_off_req  = 1'b0;
         hold_off_left = HoldOffCycles - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap_left != 0) begin
         recv_gap_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_gap_left = receiver_eager ? 0 : pick_gap();
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic queue_req(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] value);
      deq_request_type item;
      item.op    = op;
      item.value = value;
      queued_requests.insert(queued_requests.size(), item);
   endtask

   function automatic logic [DataWidth-1:0] random_word();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Pick pushes more often while filling and pops more often while draining, so the fill
   // sweeps between empty and the limit and the pointers wrap around the ring.
   function automatic logic [OpWidth-1:0] random_op(input bit filling);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 4)  return $urandom_range(1) ? OpSpare7 : OpSpare6;
      if (roll < 14) return $urandom_range(1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
      if ((roll < 70) == filling) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   task automatic queue_random_phase(input int count);
      bit filling;
      int run_left;
      filling  = ($urandom_range(1) != 0);
      run_left = $urandom_range(40, 6);
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            filling  = ~filling;
            run_left = $urandom_range(40, 6);
         end
         run_left--;
         queue_req(random_op(filling), random_word());
      end
   endtask

   // Wait until every queued request is sent and answered, then let the pipeline settle.
   task automatic wait_for_idle();
      while (queued_requests.size() != 0 || reqs_offered != reqs_taken ||
             predicted_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CountWidth-1:0] limit);
      wait_for_idle();
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_capacity_limit <= limit;
      do @(posedge clock); while (!csr_ready);
      cap_setting = limit;
      settings_applied++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset capacity: every read op on an empty queue, spare codes, the extreme words,
      // a front push that wraps the head below slot zero, and reads from both ends.
      queue_req(OP_POP_FRONT, random_word());
      queue_req(OP_POP_BACK, random_word());
      queue_req(OP_PEEK_FRONT, random_word());
      queue_req(OP_PEEK_BACK, random_word());
      queue_req(OpSpare6, random_word());
      queue_req(OpSpare7, random_word());
      queue_req(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_req(OP_PUSH_BACK, 32'h8000_0000);
      queue_req(OpSpare7, random_word());
      queue_req(OP_PEEK_FRONT, random_word());
      queue_req(OP_PEEK_BACK, random_word());
      queue_req(OP_POP_FRONT, random_word());
      queue_req(OP_POP_BACK, random_word());

      // Zero capacity: every push reports full.
      write_capacity(5'd0);
      queue_req(OP_PUSH_FRONT, random_word());
      queue_req(OP_PUSH_BACK, random_word());

      // Capacity two: fill up, overflow once, and leave two words stored.
      write_capacity(5'd2);
      queue_req(OP_PUSH_BACK, '0);
      queue_req(OP_PUSH_FRONT, '1);
      queue_req(OP_PUSH_BACK, 32'd5);
      queue_req(OP_PEEK_BACK, random_word());
      queue_req(OP_PEEK_FRONT, random_word());

      // Lower the limit below the fill: keep the words, reject pushes until drained.
      write_capacity(5'd1);
      queue_req(OP_PUSH_FRONT, random_word());
      queue_req(OP_POP_BACK, random_word());
      queue_req(OP_PUSH_BACK, random_word());
      queue_req(OP_POP_FRONT, random_word());

      // Random phases. Phase one holds off the receiver while the sender streams; phase two
      // runs with no idling on either side.
      for (int p = 0; p < 11; p++) begin
         write_capacity(phase_limits[p]);
         sender_eager   = (p == 1 || p == 2);
         receiver_eager = (p == 2);
         hold_off_req   = (p == 1);
         queue_random_phase(PhaseItems);
      end

      wait_for_idle();
      repeat (12) @(posedge clock);

      $display("Checked %0d responses over %0d capacity writes: %0d full pushes,",
               rsps_checked, settings_applied, full_rejects);
      $display("%0d empty reads, peak fill %0d", empty_hits, peak_fill);
      if (mismatches == 0 && predicted_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TimeoutCycles * ClockPeriod);
      $display("Timed out with %0d responses outstanding", predicted_responses.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ----- double_ended_queue_unit.f -----
rtl/core/deq_pkg.sv
rtl/core/deq_front.sv
rtl/core/deq_cmd_fifo.sv
rtl/core/deq_back.sv
rtl/core/double_ended_queue_unit.sv
tb/tb_double_ended_queue_unit.sv
